/* rtl/core/cle_pkg.sv */
package cle_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] char_in;
  } item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] data_byte;
    logic       last_of_run;
    logic       line_empty;
    logic [6:0] echo_pending;
  } result_t;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_BACKSPACE,
    OP_RETURN,
    OP_GET
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GET_OUT,
    ST_GET_ERR,
    ST_BS_SPACE,
    ST_BS_BACK,
    ST_CR_LF,
    ST_LINE_FIRST,
    ST_LINE_LOOK,
    ST_LINE_LAST,
    ST_LINE_EMPTY
  } back_state_t;

  localparam logic       CMD_PUT = 1'b0;
  localparam logic       CMD_GET = 1'b1;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [7:0] KEY_BACKSPACE = 8'h08;
  localparam logic [7:0] KEY_CR        = 8'h0D;
  localparam logic [7:0] KEY_LF        = 8'h0A;
  localparam logic [7:0] KEY_SPACE     = 8'h20;

  localparam int QUEUE_DEPTH = 2;

endpackage

/* rtl/core/cle_front.sv */
module cle_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  cle_pkg::item_t item,
  output logic           op_valid,
  input  logic           op_stall,
  output cle_pkg::op_t   op
);
  import cle_pkg::*;

  logic take;
  op_t  op_class;

  assign take       = !op_valid || !op_stall;
  assign item_stall = !take;

  always_comb begin
    op_class.data = item.char_in;
    if (item.command == CMD_GET) begin
      op_class.kind = OP_GET;
    end else if (item.char_in == KEY_BACKSPACE) begin
      op_class.kind = OP_BACKSPACE;
    end else if (item.char_in == KEY_CR) begin
      op_class.kind = OP_RETURN;
    end else begin
      op_class.kind = OP_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (take) begin
      op_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item_valid) begin
      op <= op_class;
    end
  end

endmodule

/* rtl/core/cle_queue.sv */
module cle_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_stall,
  input  cle_pkg::op_t push_op,
  output logic         pop_valid,
  input  logic         pop,
  output cle_pkg::op_t pop_op
);
  import cle_pkg::*;

  localparam int QI = $clog2(QUEUE_DEPTH);
  localparam int QC = $clog2(QUEUE_DEPTH + 1);

  op_t           slots [QUEUE_DEPTH];
  logic [QI-1:0] wr_ptr;
  logic [QI-1:0] rd_ptr;
  logic [QC-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_stall = (count == QC'(QUEUE_DEPTH));
  assign do_push    = push_valid && !push_stall;
  assign pop_valid  = (count != '0);
  assign do_pop     = pop && pop_valid;
  assign pop_op     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QI'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QI'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

/* rtl/core/cle_back.sv */
module cle_back #(
  parameter int ECHO_DEPTH  = 64,
  parameter int LINE_LENGTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  output logic             op_pop,
  input  cle_pkg::op_t     op,
  output logic             result_valid,
  input  logic             result_stall,
  output cle_pkg::result_t result
);
  import cle_pkg::*;

  localparam int EI = (ECHO_DEPTH > 1) ? $clog2(ECHO_DEPTH) : 1;
  localparam int CW = $clog2(ECHO_DEPTH + 1);
  localparam int LI = $clog2(LINE_LENGTH);
  localparam int FW = $clog2(LINE_LENGTH + 1);

  back_state_t   state;
  back_state_t   state_next;

  logic [7:0]    echo_mem [ECHO_DEPTH];
  logic [EI-1:0] echo_head;
  logic [EI-1:0] echo_tail;
  logic [CW-1:0] echo_count;
  logic [7:0]    echo_rdata;
  logic          echo_push;
  logic [7:0]    echo_push_byte;
  logic          echo_pop;
  logic          do_push;

  logic [7:0]    line_mem [LINE_LENGTH];
  logic [FW-1:0] line_fill;
  logic [FW-1:0] line_fill_next;
  logic [LI-1:0] line_limit;
  logic          limit_load;
  logic [LI-1:0] line_pos;
  logic [LI-1:0] line_pos_next;
  logic [7:0]    cur_byte;
  logic [7:0]    cur_byte_next;
  logic [7:0]    line_rdata;
  logic          line_wr_en;
  logic          line_rd_en;
  logic [LI-1:0] line_rd_addr;

  logic          out_free;
  logic          emit;
  result_t       emit_result;

  assign out_free = !result_valid || !result_stall;
  assign do_push  = echo_push && (echo_count != CW'(ECHO_DEPTH));

  always_comb begin
    state_next     = state;
    op_pop         = 1'b0;
    echo_push      = 1'b0;
    echo_push_byte = op.data;
    echo_pop       = 1'b0;
    line_wr_en     = 1'b0;
    line_fill_next = line_fill;
    limit_load     = 1'b0;
    line_rd_en     = 1'b0;
    line_rd_addr   = '0;
    line_pos_next  = line_pos;
    cur_byte_next  = cur_byte;
    emit           = 1'b0;
    emit_result.result_kind  = KIND_LINE;
    emit_result.data_byte    = '0;
    emit_result.last_of_run  = 1'b1;
    emit_result.line_empty   = 1'b0;
    emit_result.echo_pending = 7'(echo_count);
    case (state)
      ST_IDLE: begin
        if (op_valid) begin
          op_pop = 1'b1;
          case (op.kind)
            OP_GET: begin
              if (echo_count == '0) begin
                state_next = ST_GET_ERR;
              end else begin
                echo_pop   = 1'b1;
                state_next = ST_GET_OUT;
              end
            end
            OP_BACKSPACE: begin
              if (line_fill != '0) begin
                line_fill_next = line_fill - 1'b1;
                echo_push      = 1'b1;
                echo_push_byte = KEY_BACKSPACE;
                state_next     = ST_BS_SPACE;
              end
            end
            OP_RETURN: begin
              echo_push      = 1'b1;
              echo_push_byte = KEY_CR;
              limit_load     = 1'b1;
              line_fill_next = '0;
              state_next     = ST_CR_LF;
            end
            default: begin
              echo_push = 1'b1;
              if (line_fill != FW'(LINE_LENGTH)) begin
                line_wr_en     = 1'b1;
                line_fill_next = line_fill + 1'b1;
              end
            end
          endcase
        end
      end
      ST_GET_OUT: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_result.result_kind = KIND_ECHO;
          emit_result.data_byte   = echo_rdata;
          state_next              = ST_IDLE;
        end
      end
      ST_GET_ERR: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_result.result_kind = KIND_EMPTY;
          state_next              = ST_IDLE;
        end
      end
      ST_BS_SPACE: begin
        echo_push      = 1'b1;
        echo_push_byte = KEY_SPACE;
        state_next     = ST_BS_BACK;
      end
      ST_BS_BACK: begin
        echo_push      = 1'b1;
        echo_push_byte = KEY_BACKSPACE;
        state_next     = ST_IDLE;
      end
      ST_CR_LF: begin
        echo_push      = 1'b1;
        echo_push_byte = KEY_LF;
        if (line_limit == '0) begin
          state_next = ST_LINE_EMPTY;
        end else begin
          line_rd_en = 1'b1;
          state_next = ST_LINE_FIRST;
        end
      end
      ST_LINE_FIRST: begin
        if (line_rdata == '0) begin
          if (out_free) begin
            emit                   = 1'b1;
            emit_result.line_empty = 1'b1;
            state_next             = ST_IDLE;
          end
        end else begin
          cur_byte_next = line_rdata;
          line_pos_next = LI'(1);
          if (line_limit == LI'(1)) begin
            state_next = ST_LINE_LAST;
          end else begin
            line_rd_en   = 1'b1;
            line_rd_addr = LI'(1);
            state_next   = ST_LINE_LOOK;
          end
        end
      end
      ST_LINE_LOOK: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_result.data_byte   = cur_byte;
          emit_result.last_of_run = (line_rdata == '0);
          if (line_rdata == '0) begin
            state_next = ST_IDLE;
          end else begin
            cur_byte_next = line_rdata;
            line_pos_next = line_pos + 1'b1;
            if (line_pos + 1'b1 == line_limit) begin
              state_next = ST_LINE_LAST;
            end else begin
              line_rd_en   = 1'b1;
              line_rd_addr = line_pos + 1'b1;
            end
          end
        end
      end
      ST_LINE_LAST: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_result.data_byte = cur_byte;
          state_next            = ST_IDLE;
        end
      end
      ST_LINE_EMPTY: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_result.line_empty = 1'b1;
          state_next             = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      echo_head    <= '0;
      echo_tail    <= '0;
      echo_count   <= '0;
      line_fill    <= '0;
      result_valid <= 1'b0;
    end else begin
      state     <= state_next;
      line_fill <= line_fill_next;
      if (do_push) begin
        echo_tail  <= (echo_tail == EI'(ECHO_DEPTH - 1)) ? '0 : echo_tail + 1'b1;
        echo_count <= echo_count + 1'b1;
      end else if (echo_pop) begin
        echo_head  <= (echo_head == EI'(ECHO_DEPTH - 1)) ? '0 : echo_head + 1'b1;
        echo_count <= echo_count - 1'b1;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    line_pos <= line_pos_next;
    cur_byte <= cur_byte_next;
    if (limit_load) begin
      line_limit <= (line_fill >= FW'(LINE_LENGTH - 1)) ? LI'(LINE_LENGTH - 1)
                                                        : line_fill[LI-1:0];
    end
    if (emit) begin
      result <= emit_result;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      echo_mem[echo_tail] <= echo_push_byte;
    end
    if (echo_pop) begin
      echo_rdata <= echo_mem[echo_head];
    end
  end

  always_ff @(posedge clk) begin
    if (line_wr_en) begin
      line_mem[line_fill[LI-1:0]] <= op.data;
    end
    if (line_rd_en) begin
      line_rdata <= line_mem[line_rd_addr];
    end
  end

  a_echo_bound: assert property (@(posedge clk) disable iff (rst)
    echo_count <= CW'(ECHO_DEPTH))
    else $error("Echo queue holds more words than its depth.");

  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    line_fill <= FW'(LINE_LENGTH))
    else $error("Line fill exceeds the line length.");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LINE_LOOK || state == ST_LINE_LAST) |-> (line_pos <= line_limit))
    else $error("Line walk has run past the line limit.");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.line_empty) |->
      (result.last_of_run && result.result_kind == KIND_LINE && result.data_byte == '0))
    else $error("Empty line word is not a single line word.");

  a_line_reset: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CR_LF) |-> (line_fill == '0))
    else $error("Line fill not cleared on carriage return.");

endmodule

/* rtl/core/console_line_editor_echo_core.sv */
// Console line editor with echo queue. A word carries either a put of one
// received byte or a get of the oldest echo byte. Each word passes an input
// register and a two-entry queue before the sequencer handles it, so the
// input side keeps taking words while a result waits to be taken. In the
// sequencer an ordinary byte is handled in the idle state; a backspace on a
// non-empty line echoes backspace, space, backspace (one echo memory write
// per cycle); a get reads the echo memory, then emits; a carriage return
// echoes CR and LF, then reads the line buffer one byte per cycle while the
// output is not stalled. Results leave through an output register; a get
// always yields one result; a carriage return yields the line's bytes up to
// the first zero byte, at most LINE_LENGTH-1, or one empty-line result.
module console_line_editor_echo_core #(
  parameter int ECHO_DEPTH  = 64,
  parameter int LINE_LENGTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  cle_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output cle_pkg::result_t result
);
  import cle_pkg::*;

  logic front_valid;
  logic front_stall;
  op_t  front_op;
  logic queue_valid;
  logic queue_pop;
  op_t  queue_op;

  cle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .op_valid   (front_valid),
    .op_stall   (front_stall),
    .op         (front_op)
  );

  cle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .push_op    (front_op),
    .pop_valid  (queue_valid),
    .pop        (queue_pop),
    .pop_op     (queue_op)
  );

  cle_back #(
    .ECHO_DEPTH  (ECHO_DEPTH),
    .LINE_LENGTH (LINE_LENGTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (queue_valid),
    .op_pop       (queue_pop),
    .op           (queue_op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
